/* src/nssam_pkg.sv */
// ----------------------------------------------------------------------------
// nssam_pkg
// Shared types and constants for the nine-slice source address mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nssam_pkg;

	// coordinate and index widths
	localparam int COORD_BITS   = 12;
	localparam int INDEX_BITS   = 2 * COORD_BITS;
	localparam int SPAN_BITS    = COORD_BITS + 2;
	localparam int CFG_IDX_BITS = 3;

	typedef logic [COORD_BITS-1:0]       coord_t;
	typedef logic [INDEX_BITS-1:0]       index_t;
	typedef logic signed [SPAN_BITS-1:0] span_t;

	// configuration register map
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SRC_WIDTH     = CFG_IDX_BITS'(0),
		REG_SRC_HEIGHT    = CFG_IDX_BITS'(1),
		REG_DST_WIDTH     = CFG_IDX_BITS'(2),
		REG_DST_HEIGHT    = CFG_IDX_BITS'(3),
		REG_BORDER_LEFT   = CFG_IDX_BITS'(4),
		REG_BORDER_RIGHT  = CFG_IDX_BITS'(5),
		REG_BORDER_TOP    = CFG_IDX_BITS'(6),
		REG_BORDER_BOTTOM = CFG_IDX_BITS'(7)
	} cfg_reg_t;

	// request word: one destination pixel
	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
	} req_word_t;

	// response word: the source pixel that lands there
	typedef struct packed {
		coord_t src_x;
		coord_t src_y;
		index_t src_pixel_index;
		logic   covered;
	} rsp_word_t;

	// per-axis context that rides alongside the centre division
	typedef struct packed {
		logic   hit;      // some band of this axis maps the coordinate
		logic   use_ctr;  // the winning band is the centre band
		coord_t first;    // source start of the centre band
		coord_t s_border; // source coordinate from the winning border band
		coord_t dn;       // destination centre size (divisor)
	} axis_ctx_t;

	// per-axis band decode result
	typedef struct packed {
		axis_ctx_t ctx;
		coord_t    d;     // offset into the centre band
		coord_t    sn;    // source centre size
	} axis_dec_t;

endpackage

/* src/nssam_band_decode.sv */
// ----------------------------------------------------------------------------
// nssam_band_decode
// Works out which of the three bands of one axis map a destination
// coordinate, and sets up the centre band's scaling operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nssam_band_decode (
	input  nssam_pkg::coord_t    c,
	input  nssam_pkg::coord_t    ssize,
	input  nssam_pkg::coord_t    dsize,
	input  nssam_pkg::coord_t    first,
	input  nssam_pkg::coord_t    last,
	output nssam_pkg::axis_dec_t dec
);
	import nssam_pkg::*;

	span_t c_s, ss_s, ds_s, f_s, l_s;
	span_t sn_s, dn_s, dlast_s, s2_s;
	logic  b_first, b_ctr, b_last;

	always_comb begin
		// signed views with headroom for negative band sizes
		c_s     = $signed({2'b00, c});
		ss_s    = $signed({2'b00, ssize});
		ds_s    = $signed({2'b00, dsize});
		f_s     = $signed({2'b00, first});
		l_s     = $signed({2'b00, last});
		sn_s    = ss_s - f_s - l_s;
		dn_s    = ds_s - f_s - l_s;
		dlast_s = ds_s - l_s;
		s2_s    = ss_s - ds_s + c_s;

		// first border: one to one, must lie inside the source
		b_first = (first != '0) && (c < first) && (c < ssize);
		// centre: both centre sizes positive and coordinate inside the band
		b_ctr   = !sn_s[SPAN_BITS-1] && (sn_s != '0) && !dn_s[SPAN_BITS-1] && (dn_s != '0)
			&& (c_s >= f_s) && (c_s < dlast_s);
		// last border: one to one from the end, source must not go negative
		b_last  = (last != '0) && (c_s >= dlast_s) && (c < dsize) && !s2_s[SPAN_BITS-1];

		// later bands win
		dec.ctx.hit      = b_first | b_ctr | b_last;
		dec.ctx.use_ctr  = b_ctr & ~b_last;
		dec.ctx.first    = first;
		dec.ctx.s_border = b_last ? s2_s[COORD_BITS-1:0] : c;
		dec.ctx.dn       = dn_s[COORD_BITS-1:0];
		dec.d            = c - first;
		dec.sn           = sn_s[COORD_BITS-1:0];
	end

endmodule

/* src/nssam_div_pipe.sv */
// ----------------------------------------------------------------------------
// nssam_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The dividend's
// upper half must be below the divisor, so the quotient fits a coordinate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nssam_div_pipe (
	input  logic                 clk,
	input  logic                 en,
	input  nssam_pkg::index_t    dividend,
	input  nssam_pkg::axis_ctx_t ctx_in,
	output nssam_pkg::coord_t    quotient,
	output nssam_pkg::axis_ctx_t ctx_out
);
	import nssam_pkg::*;

	localparam int STEPS = COORD_BITS;

	// stage registers, one entry per quotient bit
	coord_t    rem_s [STEPS];
	coord_t    lo_s  [STEPS];
	coord_t    quo_s [STEPS];
	axis_ctx_t ctx_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		coord_t            rem_in, lo_in, quo_in;
		axis_ctx_t         ctx_cur;
		logic [COORD_BITS:0] trial;
		logic              ge;

		// stage inputs
		if (k == 0) begin : g_head
			assign rem_in  = dividend[INDEX_BITS-1:COORD_BITS];
			assign lo_in   = dividend[COORD_BITS-1:0];
			assign quo_in  = '0;
			assign ctx_cur = ctx_in;
		end else begin : g_body
			assign rem_in  = rem_s[k-1];
			assign lo_in   = lo_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign ctx_cur = ctx_s[k-1];
		end

		// shift in one dividend bit and try the subtract
		always_comb begin
			trial = {rem_in, lo_in[COORD_BITS-1]};
			ge    = trial >= {1'b0, ctx_cur.dn};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? coord_t'(trial - {1'b0, ctx_cur.dn}) : trial[COORD_BITS-1:0];
				lo_s[k]  <= {lo_in[COORD_BITS-2:0], 1'b0};
				quo_s[k] <= {quo_in[COORD_BITS-2:0], ge};
				ctx_s[k] <= ctx_cur;
			end
		end
	end

	assign quotient = quo_s[STEPS-1];
	assign ctx_out  = ctx_s[STEPS-1];

endmodule

/* src/nine_slice_source_address_mapper_core.sv */
// ----------------------------------------------------------------------------
// nine_slice_source_address_mapper_core
// Stages: decode, centre multiply, 12 divider stages, select, index multiply.
// Throughput: one word per cycle while rsp_stall does not hold the pipeline;
// the 12-stage centre divider is fully pipelined.
// Reset: asynchronous, active low; clears valids and the input skid buffer and
// loads the register defaults (sizes 1, borders 0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nine_slice_source_address_mapper_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  nssam_pkg::req_word_t    req_data,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output nssam_pkg::rsp_word_t    rsp_data,
	input  logic                    cfg_wr_en,
	input  logic [nssam_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  nssam_pkg::coord_t       cfg_wdata
);
	import nssam_pkg::*;

	localparam int DIV_STAGES = COORD_BITS;

	// configuration registers
	coord_t src_width_q, src_height_q, dst_width_q, dst_height_q;
	coord_t border_left_q, border_right_q, border_top_q, border_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q     <= coord_t'(1);
			src_height_q    <= coord_t'(1);
			dst_width_q     <= coord_t'(1);
			dst_height_q    <= coord_t'(1);
			border_left_q   <= '0;
			border_right_q  <= '0;
			border_top_q    <= '0;
			border_bottom_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:     src_width_q     <= cfg_wdata;
				REG_SRC_HEIGHT:    src_height_q    <= cfg_wdata;
				REG_DST_WIDTH:     dst_width_q     <= cfg_wdata;
				REG_DST_HEIGHT:    dst_height_q    <= cfg_wdata;
				REG_BORDER_LEFT:   border_left_q   <= cfg_wdata;
				REG_BORDER_RIGHT:  border_right_q  <= cfg_wdata;
				REG_BORDER_TOP:    border_top_q    <= cfg_wdata;
				REG_BORDER_BOTTOM: border_bottom_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline advance: the output stage is empty or being taken
	logic en;
	logic v_s16;
	assign en = !v_s16 || !rsp_stall;

	// input skid buffer parts the request side from the pipeline stall
	logic      skid_v_q;
	req_word_t skid_q;
	logic      take_req;
	logic      in_v;
	req_word_t in_word;

	assign req_stall = skid_v_q;
	assign take_req  = req_valid && !skid_v_q;
	assign in_v      = skid_v_q || req_valid;
	assign in_word   = skid_v_q ? skid_q : req_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= 1'b0;
		end else if (take_req) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && take_req) begin
			skid_q <= req_data;
		end
	end

	// band decode for both axes
	axis_dec_t dec_x, dec_y;

	nssam_band_decode u_dec_x (
		.c     (in_word.out_x),
		.ssize (src_width_q),
		.dsize (dst_width_q),
		.first (border_left_q),
		.last  (border_right_q),
		.dec   (dec_x)
	);

	nssam_band_decode u_dec_y (
		.c     (in_word.out_y),
		.ssize (src_height_q),
		.dsize (dst_height_q),
		.first (border_top_q),
		.last  (border_bottom_q),
		.dec   (dec_y)
	);

	// s1: decoded bands
	logic      v_s1, tgt_s1;
	axis_dec_t decx_s1, decy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tgt_s1  <= (in_word.out_x < dst_width_q) && (in_word.out_y < dst_height_q);
			decx_s1 <= dec_x;
			decy_s1 <= dec_y;
		end
	end

	// s2: centre offset times source centre size
	logic      v_s2, tgt_s2;
	index_t    prodx_s2, prody_s2;
	axis_ctx_t ctxx_s2, ctxy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tgt_s2   <= tgt_s1;
			prodx_s2 <= index_t'(decx_s1.d) * index_t'(decx_s1.sn);
			prody_s2 <= index_t'(decy_s1.d) * index_t'(decy_s1.sn);
			ctxx_s2  <= decx_s1.ctx;
			ctxy_s2  <= decy_s1.ctx;
		end
	end

	// s3 to s14: divide by the destination centre size
	coord_t    qx, qy;
	axis_ctx_t ctxx_d, ctxy_d;

	nssam_div_pipe u_div_x (
		.clk      (clk),
		.en       (en),
		.dividend (prodx_s2),
		.ctx_in   (ctxx_s2),
		.quotient (qx),
		.ctx_out  (ctxx_d)
	);

	nssam_div_pipe u_div_y (
		.clk      (clk),
		.en       (en),
		.dividend (prody_s2),
		.ctx_in   (ctxy_s2),
		.quotient (qy),
		.ctx_out  (ctxy_d)
	);

	// valid and in-target flags alongside the divider stages
	logic [DIV_STAGES-1:0] v_div_s;
	logic [DIV_STAGES-1:0] tgt_div_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_div_s <= '0;
		end else if (en) begin
			v_div_s <= {v_div_s[DIV_STAGES-2:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tgt_div_s <= {tgt_div_s[DIV_STAGES-2:0], tgt_s2};
		end
	end

	// s15: pick the winning band per axis and apply coverage
	coord_t sx, sy;
	logic   hit;
	logic   v_s15, hit_s15;
	coord_t sx_s15, sy_s15;

	always_comb begin
		sx  = ctxx_d.use_ctr ? coord_t'(ctxx_d.first + qx) : ctxx_d.s_border;
		sy  = ctxy_d.use_ctr ? coord_t'(ctxy_d.first + qy) : ctxy_d.s_border;
		hit = tgt_div_s[DIV_STAGES-1] && ctxx_d.hit && ctxy_d.hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s15 <= v_div_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s15 <= hit;
			sx_s15  <= hit ? sx : '0;
			sy_s15  <= hit ? sy : '0;
		end
	end

	// s16: linear source index, output register
	rsp_word_t word_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s16 <= 1'b0;
		end else if (en) begin
			v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s16.src_x           <= sx_s15;
			word_s16.src_y           <= sy_s15;
			word_s16.src_pixel_index <= index_t'(sy_s15) * index_t'(src_width_q)
				+ index_t'(sx_s15);
			word_s16.covered         <= hit_s15;
		end
	end

	assign rsp_valid = v_s16;
	assign rsp_data  = word_s16;

	// an uncovered pixel reports all-zero coordinates and index
	a_uncovered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.covered |->
			rsp_data.src_x == '0 && rsp_data.src_y == '0 && rsp_data.src_pixel_index == '0)
		else $error("uncovered word carries a nonzero source address");

	// a parked request word stays put until the pipeline moves
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !en |=> skid_v_q && $stable(skid_q))
		else $error("skid buffer lost or changed its word during a stall");

	// the skid buffer only fills while the pipeline is held
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(!en))
		else $error("skid buffer filled while the pipeline was advancing");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nine-slice source address mapper core. Request
// words carry destination pixels; each accepted word is run through a
// behavioural model of the band mapping under the current geometry, and every
// response word is compared field by field with the oldest prediction. Sender
// gaps, receiver stalls and one long receiver hold exercise the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import nssam_pkg::*;

	localparam int PIPE_LATENCY = 16;
	localparam int LONG_HOLD    = 80;
	localparam int PHASE_WORDS  = 85;
	localparam int RAND_PHASES  = 10;

	// bands of one axis
	localparam int BAND_FIRST  = 0;
	localparam int BAND_CENTRE = 1;
	localparam int BAND_LAST   = 2;

	// receiver stall patterns
	localparam int STALL_NONE     = 0;
	localparam int STALL_LIGHT    = 1;
	localparam int STALL_HEAVY    = 2;
	localparam int STALL_PERIODIC = 3;

	// behavioural model of the mapper plus the words still in flight
	class src_addr_ledger;
		rsp_word_t pending_addrs[$];
		int        geom[8];
		int        fail_count;
		int        checked_count;

		function new();
			geom[REG_SRC_WIDTH]     = 1;
			geom[REG_SRC_HEIGHT]    = 1;
			geom[REG_DST_WIDTH]     = 1;
			geom[REG_DST_HEIGHT]    = 1;
			geom[REG_BORDER_LEFT]   = 0;
			geom[REG_BORDER_RIGHT]  = 0;
			geom[REG_BORDER_TOP]    = 0;
			geom[REG_BORDER_BOTTOM] = 0;
			fail_count    = 0;
			checked_count = 0;
		endfunction

		function void set_reg(cfg_reg_t r, coord_t v);
			geom[r] = int'(v);
		endfunction

		// source coordinate of c through one band, 0 when the band misses
		function bit band_source(int b, int c, int ssize, int dsize, int first, int last,
				output int s);
			int d0, dn, s0, sn;
			s = 0;
			case (b)
			BAND_FIRST: begin
				d0 = 0; dn = first; s0 = 0; sn = first;
				if (first <= 0) return 0;
			end
			BAND_CENTRE: begin
				d0 = first; dn = dsize - first - last;
				s0 = first; sn = ssize - first - last;
				if (sn <= 0) return 0;
			end
			default: begin
				d0 = dsize - last; dn = last; s0 = ssize - last; sn = last;
				if (last <= 0) return 0;
			end
			endcase
			if (dn <= 0 || c < d0 || c >= d0 + dn) return 0;
			s = s0 + ((c - d0) * sn) / dn;
			return 1;
		endfunction

		// later regions in row-major order overwrite earlier ones
		function rsp_word_t map_pixel(req_word_t w);
			rsp_word_t r;
			int x, y, sx, sy, bx, by, sw, sh;
			bit hit;
			x = int'(w.out_x);
			y = int'(w.out_y);
			sw = geom[REG_SRC_WIDTH];
			sh = geom[REG_SRC_HEIGHT];
			r = '0;
			hit = 0;
			bx = 0;
			by = 0;
			if (x < geom[REG_DST_WIDTH] && y < geom[REG_DST_HEIGHT]) begin
				for (int rb = BAND_FIRST; rb <= BAND_LAST; rb++) begin
					if (!band_source(rb, y, sh, geom[REG_DST_HEIGHT], geom[REG_BORDER_TOP],
							geom[REG_BORDER_BOTTOM], sy))
						continue;
					if (sy < 0 || sy >= sh) continue;
					for (int cb = BAND_FIRST; cb <= BAND_LAST; cb++) begin
						if (!band_source(cb, x, sw, geom[REG_DST_WIDTH],
								geom[REG_BORDER_LEFT], geom[REG_BORDER_RIGHT], sx))
							continue;
						if (sx < 0 || sx >= sw) continue;
						bx = sx;
						by = sy;
						hit = 1;
					end
				end
			end
			if (hit) begin
				r.src_x           = coord_t'(bx);
				r.src_y           = coord_t'(by);
				r.src_pixel_index = index_t'(by * sw + bx);
				r.covered         = 1'b1;
			end
			return r;
		endfunction

		function void note_pixel(req_word_t w);
			pending_addrs.push_back(map_pixel(w));
		endfunction

		function void match_address(rsp_word_t got);
			rsp_word_t want;
			if (pending_addrs.size() == 0) begin
				$error("response word %h with no request outstanding", got);
				fail_count++;
				return;
			end
			want = pending_addrs.pop_front();
			checked_count++;
			if (got.src_x !== want.src_x) begin
				$error("src_x: expected %0d, got %0d", want.src_x, got.src_x);
				fail_count++;
			end
			if (got.src_y !== want.src_y) begin
				$error("src_y: expected %0d, got %0d", want.src_y, got.src_y);
				fail_count++;
			end
			if (got.src_pixel_index !== want.src_pixel_index) begin
				$error("src_pixel_index: expected %0d, got %0d",
					want.src_pixel_index, got.src_pixel_index);
				fail_count++;
			end
			if (got.covered !== want.covered) begin
				$error("covered: expected %0d, got %0d", want.covered, got.covered);
				fail_count++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_stall;
	req_word_t               req_data;
	logic                    rsp_valid;
	logic                    rsp_stall;
	rsp_word_t               rsp_data;
	logic                    cfg_wr_en;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	coord_t                  cfg_wdata;

	src_addr_ledger ledger = new();

	int  words_sent;
	int  settings_run;
	int  long_holds;
	int  burst_left;
	bit  gaps_on;
	bit  long_hold_req;

	nine_slice_source_address_mapper_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// run limit
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// receiver stall pattern, with a long hold on request
	initial begin
		int mode, left;
		rsp_stall = 1'b0;
		long_hold_req = 1'b0;
		long_holds = 0;
		mode = STALL_NONE;
		left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				rsp_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				rsp_stall = 1'b0;
				long_hold_req = 1'b0;
				long_holds++;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
					left = $urandom_range(20, 200);
				end
				left--;
				case (mode)
				STALL_NONE:  rsp_stall = 1'b0;
				STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
				STALL_HEAVY: rsp_stall = ($urandom_range(0, 3) != 0);
				default:     rsp_stall = (left % 5 < 2);
				endcase
			end
		end
	end

	// response checking
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) ledger.match_address(rsp_data);
	end

	function automatic req_word_t xy(int x, int y);
		req_word_t w;
		w.out_x = coord_t'(x);
		w.out_y = coord_t'(y);
		return w;
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(0, 4))
		0: return 0;
		1: return 1;
		2: return 4094;
		3: return 4095;
		default: return $urandom_range(0, 4095);
		endcase
	endfunction

	// mostly inside the target, sometimes on its edge or anywhere
	function automatic coord_t pick_coord(int dsize);
		int hi;
		hi = (dsize + 2 > 4095) ? 4095 : dsize + 2;
		case ($urandom_range(0, 9))
		0: return coord_t'($urandom_range(0, 4095));
		1: return coord_t'(dsize - int'($urandom_range(0, 1)));
		2: return coord_t'(pick_extreme());
		default: return coord_t'($urandom_range(0, hi));
		endcase
	endfunction

	// offer one request word, in bursts with random gaps
	task automatic offer_pixel(input req_word_t w);
		if (gaps_on) begin
			if (burst_left == 0) begin
				req_valid = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		req_valid = 1'b1;
		req_data  = w;
		do @(posedge clk); while (req_stall);
		ledger.note_pixel(w);
		words_sent++;
		@(negedge clk);
	endtask

	// hold the sender until every outstanding word has returned
	task automatic settle_idle();
		req_valid = 1'b0;
		while (ledger.pending_addrs.size() != 0) @(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_geometry(input int sw, sh, dw, dh, bl, br, bt, bb);
		coord_t   vals[8];
		cfg_reg_t r;
		vals[REG_SRC_WIDTH]     = coord_t'(sw);
		vals[REG_SRC_HEIGHT]    = coord_t'(sh);
		vals[REG_DST_WIDTH]     = coord_t'(dw);
		vals[REG_DST_HEIGHT]    = coord_t'(dh);
		vals[REG_BORDER_LEFT]   = coord_t'(bl);
		vals[REG_BORDER_RIGHT]  = coord_t'(br);
		vals[REG_BORDER_TOP]    = coord_t'(bt);
		vals[REG_BORDER_BOTTOM] = coord_t'(bb);
		settle_idle();
		r = REG_SRC_WIDTH;
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en = 1'b1;
			cfg_index = r;
			cfg_wdata = vals[r];
			ledger.set_reg(r, vals[r]);
			@(negedge clk);
			r = r.next();
		end
		cfg_wr_en = 1'b0;
		settings_run++;
	endtask

	// one random geometry followed by a stream of pixels
	task automatic run_random_phase(input bit hold);
		int sw, sh, dw, dh, bl, br, bt, bb;
		case ($urandom_range(0, 4))
		0: begin
			sw = $urandom_range(1, 64);  sh = $urandom_range(1, 64);
			dw = $urandom_range(1, 160); dh = $urandom_range(1, 160);
			bl = $urandom_range(0, sw / 3); br = $urandom_range(0, sw / 3);
			bt = $urandom_range(0, sh / 3); bb = $urandom_range(0, sh / 3);
		end
		1: begin
			sw = $urandom_range(1, 20);     sh = $urandom_range(1, 20);
			dw = $urandom_range(500, 4095); dh = $urandom_range(500, 4095);
			bl = $urandom_range(0, sw / 2); br = $urandom_range(0, sw / 2);
			bt = $urandom_range(0, sh / 2); bb = $urandom_range(0, sh / 2);
		end
		2: begin
			sw = $urandom_range(200, 4095); sh = $urandom_range(200, 4095);
			dw = $urandom_range(1, 64);     dh = $urandom_range(1, 64);
			bl = $urandom_range(0, dw / 2); br = $urandom_range(0, dw / 2);
			bt = $urandom_range(0, dh / 2); bb = $urandom_range(0, dh / 2);
		end
		3: begin
			sw = $urandom_range(1, 16); sh = $urandom_range(1, 16);
			dw = $urandom_range(1, 24); dh = $urandom_range(1, 24);
			bl = $urandom_range(0, 30); br = $urandom_range(0, 30);
			bt = $urandom_range(0, 30); bb = $urandom_range(0, 30);
		end
		default: begin
			sw = pick_extreme(); sh = pick_extreme();
			dw = pick_extreme(); dh = pick_extreme();
			bl = pick_extreme(); br = pick_extreme();
			bt = pick_extreme(); bb = pick_extreme();
		end
		endcase
		write_geometry(sw, sh, dw, dh, bl, br, bt, bb);
		// receiver holds off while the sender keeps pushing words
		if (hold) long_hold_req = 1'b1;
		for (int i = 0; i < PHASE_WORDS; i++)
			offer_pixel(xy(int'(pick_coord(dw)), int'(pick_coord(dh))));
	endtask

	// stimulus
	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req_data     = '0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		words_sent   = 0;
		settings_run = 0;
		burst_left   = 0;
		gaps_on      = 1'b1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// reset geometry: a single source pixel on a single target pixel
		offer_pixel(xy(0, 0));
		offer_pixel(xy(1, 0));
		offer_pixel(xy(4095, 4095));

		// ordinary nine-slice, every band and the target edge
		write_geometry(16, 12, 40, 30, 3, 4, 2, 5);
		offer_pixel(xy(0, 0));
		offer_pixel(xy(39, 29));
		offer_pixel(xy(2, 1));
		offer_pixel(xy(3, 2));
		offer_pixel(xy(36, 25));
		offer_pixel(xy(35, 24));
		offer_pixel(xy(20, 15));
		offer_pixel(xy(40, 0));
		offer_pixel(xy(0, 30));
		offer_pixel(xy(4095, 4095));

		// borders beyond target and source: overlaps and out-of-source pixels
		write_geometry(6, 6, 10, 10, 8, 8, 7, 7);
		offer_pixel(xy(0, 0));
		offer_pixel(xy(5, 5));
		offer_pixel(xy(9, 9));
		offer_pixel(xy(3, 7));

		// no source centre: the middle of the target stays unwritten
		write_geometry(2, 2, 10, 10, 1, 1, 1, 1);
		offer_pixel(xy(5, 5));
		offer_pixel(xy(0, 0));
		offer_pixel(xy(9, 9));
		offer_pixel(xy(0, 5));

		// largest sizes and borders
		write_geometry(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
		offer_pixel(xy(4094, 4094));
		offer_pixel(xy(0, 0));

		// zero sizes cover nothing
		write_geometry(0, 0, 0, 0, 0, 0, 0, 0);
		offer_pixel(xy(0, 0));

		// random geometries; one phase runs flat out into a long receiver hold
		for (int p = 0; p < RAND_PHASES; p++) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if (p == 2) gaps_on = 1'b0;
			run_random_phase(p == 2);
		end

		settle_idle();
		if (ledger.pending_addrs.size() != 0) begin
			$error("%0d response words never arrived", ledger.pending_addrs.size());
			ledger.fail_count++;
		end
		$display("sent %0d request words across %0d geometry settings",
			words_sent, settings_run);
		$display("checked %0d response words, %0d long receiver holds, %0d errors",
			ledger.checked_count, long_holds, ledger.fail_count);
		if (ledger.fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* files.f */
src/nssam_pkg.sv
src/nssam_band_decode.sv
src/nssam_div_pipe.sv
src/nine_slice_source_address_mapper_core.sv
tb/testbench.sv
